// ===== rtl/minmax_contrast_stretch_macros.svh =====
// Assertion macros used by the checker file of the contrast stretch block.
`ifndef MINMAX_CONTRAST_STRETCH_MACROS_SVH
`define MINMAX_CONTRAST_STRETCH_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MMCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define MMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mmcs_pkg.sv =====
// Shared types and constants of the min/max contrast stretch block.
package mmcs_pkg;

	localparam int CFG_W = 8;
	localparam int OUT_W = 8;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes on the configuration port
	localparam logic REG_OUT_LOW  = 1'b0;
	localparam logic REG_OUT_HIGH = 1'b1;

	// Request kinds
	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_MAP     = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] out_low;
		logic [CFG_W-1:0] out_high;
	} cfg_t;

endpackage

// ===== rtl/mmcs_front.sv =====
// Front end: accepts beats, tracks the extremes, prepares map jobs for the queue.
module mmcs_front import mmcs_pkg::*; #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     q_full,
	input  logic                     req_type,
	input  logic                     first_of_image,
	input  logic [SAMPLE_BITS-1:0]   sample_value,
	output logic                     q_wr,
	output logic [2*SAMPLE_BITS+1:0] q_wdata
);

	localparam int SB = SAMPLE_BITS;

	logic [SB-1:0] seen_low_q;
	logic [SB-1:0] seen_high_q;
	logic          accept;
	logic [SB:0]   dv;
	logic [SB-1:0] den;
	logic          flat;

	assign accept = push && !q_full;

	// Track the darkest and brightest component of the measure pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_low_q  <= '0;
			seen_high_q <= '0;
		end else if (accept && (req_type == REQ_MEASURE)) begin
			if (first_of_image) begin
				seen_low_q  <= sample_value;
				seen_high_q <= sample_value;
			end else begin
				if (sample_value < seen_low_q)
					seen_low_q <= sample_value;
				if (sample_value > seen_high_q)
					seen_high_q <= sample_value;
			end
		end
	end

	// Offset from the low mark, measured range and flat flag of a map beat
	assign dv   = {1'b0, sample_value} - {1'b0, seen_low_q};
	assign den  = seen_high_q - seen_low_q;
	assign flat = (seen_high_q <= seen_low_q);

	assign q_wr    = accept && (req_type == REQ_MAP);
	assign q_wdata = {flat, den, dv};

endmodule

// ===== rtl/mmcs_queue.sv =====
// Short queue of map jobs between the front and back ends.
module mmcs_queue import mmcs_pkg::*; #(
	parameter int WIDTH = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== rtl/mmcs_back.sv =====
// Back end: forms the numerator, divides bit-serially, clamps and holds the result.
module mmcs_back import mmcs_pkg::*; #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_empty,
	input  logic [2*SAMPLE_BITS+1:0] q_rdata,
	output logic                     q_rd,
	input  logic                     pop,
	output logic                     empty,
	output logic [OUT_W-1:0]         mapped_value
);

	localparam int SB = SAMPLE_BITS;
	localparam int W  = 2 * SB + 10;
	localparam int CW = $clog2(SB + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_SUM  = 5'b00100,
		S_DIV  = 5'b01000,
		S_PUT  = 5'b10000
	} state_t;

	state_t               state_q;
	logic                 out_valid_q;
	logic [CW-1:0]        cnt_q;
	logic signed [SB:0]   dv_q;
	logic [SB-1:0]        den_q;
	logic                 flat_q;
	logic signed [SB+9:0] p1_q;
	logic [SB+7:0]        p2_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         dsh_q;
	logic [SB-1:0]        quot_q;
	logic [OUT_W-1:0]     res_q;
	logic [OUT_W-1:0]     mapped_q;

	logic signed [8:0]    slope;
	logic [SB+10:0]       num;
	logic [W-1:0]         num_ext;
	logic [W-1:0]         den_ext;
	logic [W-1:0]         lim;
	logic                 ge;
	logic [W-1:0]         rem_nxt;
	logic [SB:0]          quot_wide;
	logic [SB-1:0]        quot_nxt;
	logic [SB+7:0]        quot_out;
	logic [SB+7:0]        sat_out;
	logic                 slot_free;

	assign slope     = $signed({1'b0, cfg.out_high}) - $signed({1'b0, cfg.out_low});
	assign num       = {p1_q[SB+9], p1_q} + {3'b000, p2_q};
	assign num_ext   = {{SB{1'b0}}, num[SB+9:0]};
	assign den_ext   = {{(W-SB){1'b0}}, den_q};
	assign lim       = den_ext << SB;
	assign ge        = (rem_q >= dsh_q);
	assign rem_nxt   = ge ? (rem_q - dsh_q) : rem_q;
	assign quot_wide = {quot_q, ge};
	assign quot_nxt  = quot_wide[SB-1:0];
	assign quot_out  = {8'h00, quot_nxt};
	assign sat_out   = {8'h00, {SB{1'b1}}};
	assign slot_free = !out_valid_q || pop;

	assign q_rd         = (state_q == S_IDLE) && !q_empty;
	assign empty        = !out_valid_q;
	assign mapped_value = mapped_q;

	// Sequence one job: fetch, multiply, sum and range check, divide, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// Raise the result slot on delivery, drop it when the beat is taken
			if ((state_q == S_PUT) && slot_free)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= flat_q ? S_PUT : S_SUM;
				end
				S_SUM: begin
					if (num[SB+10] || (num_ext >= lim)) begin
						state_q <= S_PUT;
					end else begin
						cnt_q   <= CW'(SB - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_PUT;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_PUT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the job in flight
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dv_q   <= $signed(q_rdata[SB:0]);
				den_q  <= q_rdata[2*SB:SB+1];
				flat_q <= q_rdata[2*SB+1];
			end
			S_MUL: begin
				p1_q  <= slope * dv_q;
				p2_q  <= cfg.out_low * den_q;
				res_q <= cfg.out_low;
			end
			S_SUM: begin
				rem_q  <= num_ext;
				dsh_q  <= den_ext << (SB - 1);
				quot_q <= '0;
				if (num[SB+10])
					res_q <= '0;
				else
					res_q <= sat_out[OUT_W-1:0];
			end
			S_DIV: begin
				rem_q  <= rem_nxt;
				dsh_q  <= dsh_q >> 1;
				quot_q <= quot_nxt;
				res_q  <= quot_out[OUT_W-1:0];
			end
			S_PUT: begin
				if (slot_free)
					mapped_q <= res_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

// ===== rtl/minmax_contrast_stretch.sv =====
// A map beat waits in the queue; the back end fetches, multiplies, sums, range-checks,
// divides and delivers it (flat range: no sum or divide; clamped: no divide).
// Measure beats give no result. Throughput: one measure beat per cycle unless full; map
// beats queue while the back end's restoring divider resolves one quotient bit a cycle.
// Reset (arst_n low): trackers zero, out_low 0, out_high 255, queue and result slot empty.
module minmax_contrast_stretch import mmcs_pkg::*; #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   req_type,
	input  logic                   first_of_image,
	input  logic [SAMPLE_BITS-1:0] sample_value,
	output logic                   empty,
	input  logic                   pop,
	output logic [OUT_W-1:0]       mapped_value,
	input  logic                   cfg_we,
	input  logic                   cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	localparam int ENT_W = 2 * SAMPLE_BITS + 2;

	cfg_t             cfg_q;
	logic             q_wr;
	logic [ENT_W-1:0] q_wdata;
	logic             q_rd;
	logic [ENT_W-1:0] q_rdata;
	logic             q_empty;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_low  <= '0;
			cfg_q.out_high <= '1;
		end else if (cfg_we) begin
			if (cfg_addr == REG_OUT_LOW)
				cfg_q.out_low <= cfg_wdata;
			else if (cfg_addr == REG_OUT_HIGH)
				cfg_q.out_high <= cfg_wdata;
		end
	end

	mmcs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.q_full         (full),
		.req_type       (req_type),
		.first_of_image (first_of_image),
		.sample_value   (sample_value),
		.q_wr           (q_wr),
		.q_wdata        (q_wdata)
	);

	mmcs_queue #(.WIDTH(ENT_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (full),
		.empty  (q_empty)
	);

	mmcs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_rdata      (q_rdata),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.mapped_value (mapped_value)
	);

endmodule

// ===== rtl/mmcs_checker.sv =====
// Port-level checker of the contrast stretch block and its bind.
`include "minmax_contrast_stretch_macros.svh"

module mmcs_checker import mmcs_pkg::*; #(
	parameter int SAMPLE_BITS = 8
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   push,
	input logic                   full,
	input logic                   req_type,
	input logic [SAMPLE_BITS-1:0] sample_value,
	input logic                   empty,
	input logic                   pop,
	input logic [OUT_W-1:0]       mapped_value
);

	// A waiting result beat holds until it is taken
	`MMCS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(mapped_value), "result beat changed while stalled")

	// The job queue fills only through an accepted map beat
	`MMCS_ASSERT(a_full_from_map, $rose(full) |-> $past(push && !full && (req_type == REQ_MAP)), "queue filled without a map beat")

	// Leave reset with no result and room for input
	`MMCS_ASSERT(a_reset_state, $rose(arst_n) |-> (empty && !full), "block not clear after reset")

endmodule

bind minmax_contrast_stretch mmcs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mmcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.req_type     (req_type),
	.sample_value (sample_value),
	.empty        (empty),
	.pop          (pop),
	.mapped_value (mapped_value)
);
